>>> sv/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// shared codes, widths and types of the sensor capture scheduler
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int OP_W       = 2;
    localparam int NOW_W      = 32;
    localparam int SENSOR_W   = 4;
    localparam int TARGET_W   = 20;
    localparam int PICK_W     = 3;
    localparam int MARGIN_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [OP_W-1:0] OP_NEXT_BASIC    = 2'd0;
    localparam logic [OP_W-1:0] OP_PICK_OBSTACLE = 2'd1;
    localparam logic [OP_W-1:0] OP_CAPTURE_DONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MASK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY_TARGET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATER_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PICKS       = 3'd4;

    localparam logic [TARGET_W-1:0] RST_LATENCY_TARGET  = 20'd20000;
    localparam logic [TARGET_W-1:0] RST_FIRST_THRESHOLD = 20'd1000;
    localparam logic [TARGET_W-1:0] RST_LATER_THRESHOLD = 20'd200;
    localparam logic [PICK_W-1:0]   RST_MAX_PICKS       = 3'd3;
    localparam logic [PICK_W-1:0]   PICKS_SAT           = 3'd7;

    localparam logic signed [MARGIN_W-1:0] NO_CANDIDATE_MARGIN = 32'sd99999999;

    typedef struct packed {
        logic done;
        logic round;
        logic wide;
        logic narrow;
    } t_rr_status;

endpackage

>>> sv/scs_ram.sv
// ----------------------------------------------------------------------------
// scs_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module scs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/scs_margin.sv
// ----------------------------------------------------------------------------
// scs_margin
// two stage latency margin pipeline: elapsed time, then saturated margin
// ----------------------------------------------------------------------------
module scs_margin #(
    parameter int IW = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [IW-1:0]                         i_idx,
    input  logic [scs_pkg::NOW_W-1:0]             i_last,
    input  logic [scs_pkg::NOW_W-1:0]             i_now,
    input  logic [scs_pkg::TARGET_W-1:0]          i_target,
    output logic                                  o_valid,
    output logic                                  o_active,
    output logic [IW-1:0]                         o_idx,
    output logic signed [scs_pkg::MARGIN_W-1:0]   o_margin
);

    localparam int EXT_W = scs_pkg::MARGIN_W + 2;

    logic                              r_v1;
    logic [IW-1:0]                     r_idx1;
    logic [scs_pkg::NOW_W-1:0]         r_diff;
    logic                              r_v2;
    logic [IW-1:0]                     r_idx2;
    logic signed [scs_pkg::MARGIN_W-1:0] r_margin;
    logic signed [EXT_W-1:0]           w_wide;
    logic signed [scs_pkg::MARGIN_W-1:0] w_sat;

    always_comb begin
        w_wide = $signed({{(EXT_W - scs_pkg::TARGET_W){1'b0}}, i_target})
               - $signed({{(EXT_W - scs_pkg::NOW_W){r_diff[scs_pkg::NOW_W-1]}}, r_diff});
        if (w_wide[EXT_W-1:scs_pkg::MARGIN_W-1] == '0 ||
            w_wide[EXT_W-1:scs_pkg::MARGIN_W-1] == '1) begin
            w_sat = w_wide[scs_pkg::MARGIN_W-1:0];
        end else if (w_wide[EXT_W-1]) begin
            w_sat = {1'b1, {(scs_pkg::MARGIN_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(scs_pkg::MARGIN_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_idx1   <= i_idx;
        r_diff   <= i_now - i_last;
        r_idx2   <= r_idx1;
        r_margin <= w_sat;
    end

    assign o_valid  = r_v2;
    assign o_active = r_v1 || r_v2;
    assign o_idx    = r_idx2;
    assign o_margin = r_margin;

endmodule

>>> sv/scs_rr.sv
// ----------------------------------------------------------------------------
// scs_rr
// round-robin basic pointer with rotating wide and narrow long-capture slots
// ----------------------------------------------------------------------------
module scs_rr #(
    parameter int SENSOR_COUNT    = 10,
    parameter int LONG_SLOT_COUNT = 3,
    parameter int IW              = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  logic [SENSOR_COUNT-1:0]  i_mask,
    output logic [IW-1:0]            o_ptr,
    output scs_pkg::t_rr_status      o_status
);

    localparam logic [IW-1:0] LAST_IDX = IW'(SENSOR_COUNT - 1);

    logic                       r_run;
    logic                       r_done;
    logic                       r_round;
    logic [IW-1:0]              r_ptr;
    logic [IW-1:0]              n_ptr;
    logic                       w_wrap;
    logic                       w_rotate;
    logic [LONG_SLOT_COUNT-1:0] w_wide_hit;
    logic [LONG_SLOT_COUNT-1:0] w_narrow_hit;

    assign w_wrap   = (r_ptr == LAST_IDX);
    assign n_ptr    = w_wrap ? '0 : r_ptr + 1'b1;
    assign w_rotate = r_run && !i_go && w_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_round <= 1'b0;
            r_ptr   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run   <= 1'b1;
                r_round <= 1'b0;
            end else if (r_run) begin
                r_ptr <= n_ptr;
                if (w_wrap) begin
                    r_round <= 1'b1;
                end
                if (i_mask[n_ptr]) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < LONG_SLOT_COUNT; g++) begin : gen_lane
        localparam logic [IW-1:0] WIDE_RST   = IW'((3 * g) % SENSOR_COUNT);
        localparam logic [IW-1:0] NARROW_RST = IW'((3 * g + 1) % SENSOR_COUNT);

        logic [IW-1:0] r_wide_slot;
        logic [IW-1:0] r_narrow_slot;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_wide_slot   <= WIDE_RST;
                r_narrow_slot <= NARROW_RST;
            end else if (w_rotate) begin
                r_wide_slot   <= (r_wide_slot == LAST_IDX) ? '0 : r_wide_slot + 1'b1;
                r_narrow_slot <= (r_narrow_slot == LAST_IDX) ? '0 : r_narrow_slot + 1'b1;
            end
        end

        assign w_wide_hit[g]   = (r_ptr == r_wide_slot);
        assign w_narrow_hit[g] = (r_ptr == r_narrow_slot);
    end

    assign o_ptr           = r_ptr;
    assign o_status.done   = r_done;
    assign o_status.round  = r_round;
    assign o_status.wide   = |w_wide_hit;
    assign o_status.narrow = |w_narrow_hit;

endmodule

>>> sv/sensor_capture_scheduler.sv
// ----------------------------------------------------------------------------
// sensor_capture_scheduler
// earliest-deadline capture scheduler for a ring of range sensors
// ----------------------------------------------------------------------------
// capture_done, unknown code and next_basic with empty mask finish in the cycle after the request
// next_basic: pointer steps (1 to SENSOR_COUNT), one per cycle, until an enabled sensor
// pick_obstacle: scans all SENSOR_COUNT sensors, end set by highest enabled sensor
// one request at a time; o_busy high until the result strobe, no output stall
// reset: synchronous active low, control and config registers to defaults, capture times read 0
// ----------------------------------------------------------------------------
module sensor_capture_scheduler #(
    parameter int SENSOR_COUNT    = 10,
    parameter int LONG_SLOT_COUNT = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [scs_pkg::OP_W-1:0]             i_operation,
    input  logic [scs_pkg::NOW_W-1:0]            i_now,
    input  logic [scs_pkg::SENSOR_W-1:0]         i_sensor,
    input  logic                                 i_charger_align,
    input  logic                                 i_cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    output logic                                 o_done,
    output logic                                 o_granted,
    output logic [scs_pkg::SENSOR_W-1:0]         o_chosen,
    output logic                                 o_wide_long,
    output logic                                 o_narrow_long,
    output logic                                 o_new_round,
    output logic signed [scs_pkg::MARGIN_W-1:0]  o_min_margin
);

    localparam int IW = $clog2(SENSOR_COUNT);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] SCAN_END = CW'(SENSOR_COUNT);
    localparam logic [scs_pkg::SENSOR_W:0] SENSOR_LIMIT = (scs_pkg::SENSOR_W + 1)'(SENSOR_COUNT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASIC,
        ST_SCAN
    } t_state;

    t_state                              r_state;
    logic [SENSOR_COUNT-1:0]             r_mask;
    logic [scs_pkg::TARGET_W-1:0]        r_target;
    logic [scs_pkg::TARGET_W-1:0]        r_first_thr;
    logic [scs_pkg::TARGET_W-1:0]        r_later_thr;
    logic [scs_pkg::PICK_W-1:0]          r_max_picks;
    logic [scs_pkg::PICK_W-1:0]          r_picks;
    logic [SENSOR_COUNT-1:0]             r_written;
    logic [scs_pkg::NOW_W-1:0]           r_now;
    logic                                r_align;
    logic                                r_rr_go;
    logic [CW-1:0]                       r_iss;
    logic                                r_v1;
    logic [IW-1:0]                       r_idx1;
    logic                                r_found;
    logic [IW-1:0]                       r_best_idx;
    logic signed [scs_pkg::MARGIN_W-1:0] r_best;

    logic                                r_done;
    logic                                r_granted;
    logic [scs_pkg::SENSOR_W-1:0]        r_chosen;
    logic                                r_wide_long;
    logic                                r_narrow_long;
    logic                                r_new_round;
    logic signed [scs_pkg::MARGIN_W-1:0] r_lowest;

    logic                                w_accept;
    logic                                w_any;
    logic                                w_cap_we;
    logic [IW-1:0]                       w_cap_idx;
    logic [scs_pkg::NOW_W-1:0]           w_rdata;
    logic [scs_pkg::NOW_W-1:0]           w_last;
    logic                                w_issue;
    logic                                w_issue_en;
    logic                                w_m_valid;
    logic                                w_m_active;
    logic [IW-1:0]                       w_m_idx;
    logic signed [scs_pkg::MARGIN_W-1:0] w_m_margin;
    logic                                w_scan_end;
    logic [scs_pkg::TARGET_W-1:0]        w_thr;
    logic                                w_grant;
    logic [IW-1:0]                       w_ptr;
    scs_pkg::t_rr_status                 w_rr;

    assign w_accept  = i_start && (r_state == ST_IDLE);
    assign w_any     = |r_mask;
    assign w_cap_idx = i_sensor[IW-1:0];
    assign w_cap_we  = w_accept && (i_operation == scs_pkg::OP_CAPTURE_DONE)
                    && ({1'b0, i_sensor} < SENSOR_LIMIT);

    assign w_issue    = (r_state == ST_SCAN) && (r_iss < SCAN_END);
    assign w_issue_en = w_issue && r_mask[r_iss[IW-1:0]];
    assign w_last     = r_written[r_idx1] ? w_rdata : '0;
    assign w_scan_end = (r_state == ST_SCAN) && (r_iss == SCAN_END)
                     && !r_v1 && !w_m_active;

    assign w_thr   = (r_picks == '0) ? r_first_thr : r_later_thr;
    assign w_grant = r_found && !r_align && (r_picks < r_max_picks)
                  && (r_best <= $signed({{(scs_pkg::MARGIN_W - scs_pkg::TARGET_W){1'b0}},
                                         w_thr}));

    scs_ram #(
        .WIDTH (scs_pkg::NOW_W),
        .DEPTH (SENSOR_COUNT)
    ) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (w_cap_we),
        .i_waddr (w_cap_idx),
        .i_wdata (i_now),
        .i_raddr (r_iss[IW-1:0]),
        .o_rdata (w_rdata)
    );

    scs_margin #(
        .IW (IW)
    ) u_margin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1),
        .i_idx    (r_idx1),
        .i_last   (w_last),
        .i_now    (r_now),
        .i_target (r_target),
        .o_valid  (w_m_valid),
        .o_active (w_m_active),
        .o_idx    (w_m_idx),
        .o_margin (w_m_margin)
    );

    scs_rr #(
        .SENSOR_COUNT    (SENSOR_COUNT),
        .LONG_SLOT_COUNT (LONG_SLOT_COUNT),
        .IW              (IW)
    ) u_rr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (r_rr_go),
        .i_mask   (r_mask),
        .o_ptr    (w_ptr),
        .o_status (w_rr)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '1;
            r_target    <= scs_pkg::RST_LATENCY_TARGET;
            r_first_thr <= scs_pkg::RST_FIRST_THRESHOLD;
            r_later_thr <= scs_pkg::RST_LATER_THRESHOLD;
            r_max_picks <= scs_pkg::RST_MAX_PICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                scs_pkg::CFG_SENSOR_MASK:     r_mask      <= i_cfg_wdata[SENSOR_COUNT-1:0];
                scs_pkg::CFG_LATENCY_TARGET:  r_target    <= i_cfg_wdata;
                scs_pkg::CFG_FIRST_THRESHOLD: r_first_thr <= i_cfg_wdata;
                scs_pkg::CFG_LATER_THRESHOLD: r_later_thr <= i_cfg_wdata;
                scs_pkg::CFG_MAX_PICKS:       r_max_picks <= i_cfg_wdata[scs_pkg::PICK_W-1:0];
                default: ;
            endcase
        end
    end

    // written flags of the capture time ram
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (w_cap_we) begin
            r_written[w_cap_idx] <= 1'b1;
        end
    end

    // scan read stage; the running minimum is kept in the state machine below
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_issue_en;
        end
        r_idx1 <= r_iss[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_rr_go       <= 1'b0;
            r_iss         <= '0;
            r_picks       <= '0;
            r_found       <= 1'b0;
            r_done        <= 1'b0;
            r_granted     <= 1'b0;
            r_chosen      <= '0;
            r_wide_long   <= 1'b0;
            r_narrow_long <= 1'b0;
            r_new_round   <= 1'b0;
            r_lowest      <= '0;
        end else begin
            r_rr_go <= 1'b0;
            r_done  <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_now         <= i_now;
                        r_align       <= i_charger_align;
                        r_granted     <= 1'b0;
                        r_chosen      <= '0;
                        r_wide_long   <= 1'b0;
                        r_narrow_long <= 1'b0;
                        r_new_round   <= 1'b0;
                        r_lowest      <= '0;
                        if (i_operation == scs_pkg::OP_NEXT_BASIC && w_any) begin
                            r_rr_go <= 1'b1;
                            r_state <= ST_BASIC;
                        end else if (i_operation == scs_pkg::OP_PICK_OBSTACLE) begin
                            r_iss      <= '0;
                            r_found    <= 1'b0;
                            r_best     <= scs_pkg::NO_CANDIDATE_MARGIN;
                            r_best_idx <= '0;
                            r_state    <= ST_SCAN;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                ST_BASIC: begin
                    if (w_rr.done) begin
                        r_done        <= 1'b1;
                        r_granted     <= 1'b1;
                        r_chosen      <= scs_pkg::SENSOR_W'(w_ptr);
                        r_wide_long   <= w_rr.wide && !r_align;
                        r_narrow_long <= w_rr.narrow && !r_align;
                        r_new_round   <= w_rr.round;
                        r_picks       <= '0;
                        r_state       <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (w_issue) begin
                        r_iss <= r_iss + 1'b1;
                    end
                    if (w_m_valid && (w_m_margin < r_best)) begin
                        r_best     <= w_m_margin;
                        r_best_idx <= w_m_idx;
                        r_found    <= 1'b1;
                    end
                    if (w_scan_end) begin
                        r_done   <= 1'b1;
                        r_lowest <= r_best;
                        if (w_grant) begin
                            r_granted <= 1'b1;
                            r_chosen  <= scs_pkg::SENSOR_W'(r_best_idx);
                            if (r_picks != scs_pkg::PICKS_SAT) begin
                                r_picks <= r_picks + 1'b1;
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_done          = r_done;
    assign o_granted       = r_granted;
    assign o_chosen        = r_chosen;
    assign o_wide_long     = r_wide_long;
    assign o_narrow_long   = r_narrow_long;
    assign o_new_round     = r_new_round;
    assign o_min_margin    = r_lowest;

endmodule
